// ===== hdl/vsa_pkg.sv =====
// Package: shared types, constants and command/status structs for voxel_snap_accumulate
package vsa_pkg;

    localparam int TableDepthDefault = 1024;
    localparam int FracBitsDefault   = 8;
    localparam int CountMax          = 20'hFFFFF;

    localparam logic [1:0] FuncAdd   = 2'd0;
    localparam logic [1:0] FuncRead  = 2'd1;
    localparam logic [1:0] FuncClear = 2'd2;

    localparam logic CfgSnapEnable = 1'b0;
    localparam logic CfgSnapExp    = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the input beat
        logic scan_rd;   // read entry at scan pointer
        logic scan_inc;  // advance scan pointer
        logic scan_clr;  // zero scan pointer
        logic idx_rd;    // read entry at read_index
        logic wr_upd;    // write back updated entry at hit index
        logic wr_new;    // append new entry
        logic used_clr;  // empty the table
        logic out_hit;   // result: hit (maybe dropped on saturation)
        logic out_new;   // result: new entry
        logic out_full;  // result: table full
        logic out_read;  // result: read entry
        logic out_zero;  // result: all zero but index
    } vsa_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] func;
        logic       scan_done;  // pointer reached used count
        logic       match;      // registered read data matches key
        logic       full;       // used count at depth
        logic       read_ok;    // read index below used count
        logic       sat;        // matched count saturated
    } vsa_stat_t;

endpackage

// ===== hdl/voxel_snap_accumulate.sv =====
// Top level: voxel grid downsampler with key table, configuration port and checks
//
// Usage. A command beat is taken when start is high and busy is low; func selects
// add point, read entry or clear table. Every command gives exactly one result,
// shown for one cycle with done high; the receiver cannot stall it.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 snap_enable, 1 snap_exp)
// and cfg_data; cfg_ready is always high; write only while idle.
// Sequence: an add scans the stored keys one memory read per cycle, so a miss runs
// through every used entry and a hit stops at the matching entry. A read fetches the
// entry and registers it as the result, or gives a zero result straight away when the
// index is beyond the used entries; a clear empties the table and gives a zero result.
// Busy covers the whole command; the next command is taken at the earliest in the
// cycle after the result. The key scan, one entry memory read per cycle, sets the
// rate.
// Reset empties the table (fill count to zero) and clears both registers;
// table contents are not cleared, entries beyond the fill count are never read.
module voxel_snap_accumulate #(
    parameter int TABLE_DEPTH = vsa_pkg::TableDepthDefault,
    parameter int FRAC_BITS   = vsa_pkg::FracBitsDefault
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [5:0]         cfg_data,
    input  logic [1:0]         func,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic signed [31:0] z_coord,
    input  logic signed [11:0] point_intensity,
    input  logic [7:0]         point_red,
    input  logic [7:0]         point_green,
    input  logic [7:0]         point_blue,
    input  logic [9:0]         read_index,
    output logic [9:0]         entry_index,
    output logic               is_new,
    output logic               dropped,
    output logic               entry_valid,
    output logic signed [31:0] key_x,
    output logic signed [31:0] key_y,
    output logic signed [31:0] key_z,
    output logic signed [31:0] sum_intensity,
    output logic [27:0]        sum_red,
    output logic [27:0]        sum_green,
    output logic [27:0]        sum_blue,
    output logic [19:0]        point_count
);

    logic              snap_enable_reg;
    logic signed [5:0] snap_exp_reg;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_enable_reg <= 1'b0;
            snap_exp_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vsa_pkg::CfgSnapEnable: snap_enable_reg <= cfg_data[0];
                vsa_pkg::CfgSnapExp:    snap_exp_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    vsa_pkg::vsa_cmd_t  cmd;
    vsa_pkg::vsa_stat_t stat;

    vsa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    vsa_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .snap_enable     (snap_enable_reg),
        .snap_exp        (snap_exp_reg),
        .func            (func),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .z_coord         (z_coord),
        .point_intensity (point_intensity),
        .point_red       (point_red),
        .point_green     (point_green),
        .point_blue      (point_blue),
        .read_index      (read_index),
        .cmd             (cmd),
        .stat            (stat),
        .entry_index     (entry_index),
        .is_new          (is_new),
        .dropped         (dropped),
        .entry_valid     (entry_valid),
        .key_x           (key_x),
        .key_y           (key_y),
        .key_z           (key_z),
        .sum_intensity   (sum_intensity),
        .sum_red         (sum_red),
        .sum_green       (sum_green),
        .sum_blue        (sum_blue),
        .point_count     (point_count)
    );

    // Checks
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result strobe outside a command");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe held");
    a_new_not_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(is_new && dropped)) else $error("new entry flagged dropped");
    a_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_new && cmd.wr_upd)) else $error("two table writes at once");

endmodule

// ===== hdl/vsa_datapath.sv =====
// Datapath: coordinate snapping, entry memory, scan pointer and result registers
module vsa_datapath #(
    parameter int TABLE_DEPTH = vsa_pkg::TableDepthDefault,
    parameter int FRAC_BITS   = vsa_pkg::FracBitsDefault
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                snap_enable,
    input  logic signed [5:0]   snap_exp,
    input  logic [1:0]          func,
    input  logic signed [31:0]  x_coord,
    input  logic signed [31:0]  y_coord,
    input  logic signed [31:0]  z_coord,
    input  logic signed [11:0]  point_intensity,
    input  logic [7:0]          point_red,
    input  logic [7:0]          point_green,
    input  logic [7:0]          point_blue,
    input  logic [9:0]          read_index,
    input  vsa_pkg::vsa_cmd_t   cmd,
    output vsa_pkg::vsa_stat_t  stat,
    output logic [9:0]          entry_index,
    output logic                is_new,
    output logic                dropped,
    output logic                entry_valid,
    output logic signed [31:0]  key_x,
    output logic signed [31:0]  key_y,
    output logic signed [31:0]  key_z,
    output logic signed [31:0]  sum_intensity,
    output logic [27:0]         sum_red,
    output logic [27:0]         sum_green,
    output logic [27:0]         sum_blue,
    output logic [19:0]         point_count
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
        logic [31:0] si;
        logic [27:0] sr;
        logic [27:0] sg;
        logic [27:0] sb;
        logic [19:0] cnt;
    } vsa_entry_t;

    // Snap one coordinate; sh is spacing exponent in raw units
    function automatic logic [31:0] snap(input logic [31:0] raw, input logic en,
                                         input logic signed [6:0] sh);
        logic [32:0] mag;
        logic [32:0] lim;
        logic [32:0] rem;
        logic [32:0] q;
        logic [32:0] res;
        logic        neg;
        neg = raw[31];
        mag = neg ? (33'd0 - {1'b1, raw}) : {1'b0, raw};
        lim = 33'd1 << sh[5:0];
        rem = mag & (lim - 33'd1);
        q   = mag - rem;
        if (rem > (lim >> 1))
            q = q + lim;
        res = neg ? (33'd0 - q) : q;
        if (!en || sh <= 7'sd0)
            snap = raw;
        else if (sh >= 7'sd32)
            snap = 32'd0;
        else if (!neg && q > 33'h7FFFFFFF)
            snap = 32'h80000000 - lim[31:0];
        else
            snap = res[31:0];
    endfunction

    logic signed [6:0] sh;
    assign sh = 7'(snap_exp) + 7'(FRAC_BITS);

    // Captured item
    logic [1:0]  func_reg;
    logic [31:0] kx_reg, ky_reg, kz_reg;
    logic [31:0] inten_reg;
    logic [7:0]  r_reg, g_reg, b_reg;
    logic [9:0]  ridx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            kx_reg    <= snap(x_coord, snap_enable, sh);
            ky_reg    <= snap(y_coord, snap_enable, sh);
            kz_reg    <= snap(z_coord, snap_enable, sh);
            inten_reg <= 32'(point_intensity);
            r_reg     <= point_red;
            g_reg     <= point_green;
            b_reg     <= point_blue;
            ridx_reg  <= read_index;
        end
    end

    // Scan pointer and fill count
    logic [CW-1:0] ptr_reg;
    logic [CW-1:0] rd_ptr_reg;
    logic [CW-1:0] used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            if (cmd.scan_clr)
                ptr_reg <= '0;
            else if (cmd.scan_inc)
                ptr_reg <= ptr_reg + CW'(1);
            if (cmd.used_clr)
                used_reg <= '0;
            else if (cmd.wr_new)
                used_reg <= used_reg + CW'(1);
        end
    end

    // Entry memory, one read and one write port
    vsa_entry_t    mem [TABLE_DEPTH];
    vsa_entry_t    rd_data_reg;
    logic [AW-1:0] rd_addr;
    vsa_entry_t    wr_data;
    logic [AW-1:0] wr_addr;

    assign rd_addr = cmd.idx_rd ? AW'(ridx_reg) : ptr_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd || cmd.idx_rd)
            rd_data_reg <= mem[rd_addr];
        if (cmd.wr_upd || cmd.wr_new)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd || cmd.idx_rd)
            rd_ptr_reg <= cmd.idx_rd ? CW'(ridx_reg) : ptr_reg;
    end

    // Update or new entry contents
    vsa_entry_t upd, fresh;
    always_comb
    begin
        upd     = rd_data_reg;
        upd.si  = rd_data_reg.si + inten_reg;
        upd.sr  = rd_data_reg.sr + 28'(r_reg);
        upd.sg  = rd_data_reg.sg + 28'(g_reg);
        upd.sb  = rd_data_reg.sb + 28'(b_reg);
        upd.cnt = rd_data_reg.cnt + 20'd1;
        fresh.kx  = kx_reg;
        fresh.ky  = ky_reg;
        fresh.kz  = kz_reg;
        fresh.si  = inten_reg;
        fresh.sr  = 28'(r_reg);
        fresh.sg  = 28'(g_reg);
        fresh.sb  = 28'(b_reg);
        fresh.cnt = 20'd1;
    end

    assign wr_data = cmd.wr_new ? fresh : upd;
    assign wr_addr = cmd.wr_new ? used_reg[AW-1:0] : rd_ptr_reg[AW-1:0];

    // Status back to the controller
    assign stat.func      = func_reg;
    assign stat.scan_done = (ptr_reg >= used_reg);
    assign stat.match     = (rd_data_reg.kx == kx_reg) && (rd_data_reg.ky == ky_reg)
                            && (rd_data_reg.kz == kz_reg);
    assign stat.full      = (used_reg >= CW'(TABLE_DEPTH));
    assign stat.read_ok   = ({{(CW > 10 ? CW - 10 : 0){1'b0}}, ridx_reg} < CW'(used_reg))
                            && (32'(ridx_reg) < TABLE_DEPTH);
    assign stat.sat       = (rd_data_reg.cnt == 20'(vsa_pkg::CountMax));

    // Result registers
    logic       res_new_reg, res_drop_reg, res_valid_reg;
    logic [9:0] res_idx_reg;
    vsa_entry_t res_ent_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.out_hit || cmd.out_new || cmd.out_full || cmd.out_read || cmd.out_zero)
        begin
            res_new_reg   <= cmd.out_new;
            res_drop_reg  <= cmd.out_full || (cmd.out_hit && stat.sat);
            res_valid_reg <= cmd.out_hit || cmd.out_new || cmd.out_read;
            if (cmd.out_hit)
                res_idx_reg <= 10'(rd_ptr_reg);
            else if (cmd.out_new)
                res_idx_reg <= 10'(used_reg);
            else if (cmd.out_read || (cmd.out_zero && func_reg == vsa_pkg::FuncRead))
                res_idx_reg <= ridx_reg;
            else
                res_idx_reg <= 10'd0;
            if (cmd.out_hit)
                res_ent_reg <= stat.sat ? rd_data_reg : upd;
            else if (cmd.out_new)
                res_ent_reg <= fresh;
            else if (cmd.out_read)
                res_ent_reg <= rd_data_reg;
            else
                res_ent_reg <= '0;
        end
    end

    assign entry_index   = res_idx_reg;
    assign is_new        = res_new_reg;
    assign dropped       = res_drop_reg;
    assign entry_valid   = res_valid_reg;
    assign key_x         = res_ent_reg.kx;
    assign key_y         = res_ent_reg.ky;
    assign key_z         = res_ent_reg.kz;
    assign sum_intensity = res_ent_reg.si;
    assign sum_red       = res_ent_reg.sr;
    assign sum_green     = res_ent_reg.sg;
    assign sum_blue      = res_ent_reg.sb;
    assign point_count   = res_ent_reg.cnt;

endmodule

// ===== hdl/vsa_ctrl.sv =====
// Controller: sequences capture, table scan, write-back and result strobe
module vsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  vsa_pkg::vsa_stat_t stat,
    output vsa_pkg::vsa_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DISP  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_RDWT  = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_DONE  = 7'b1000000
    } vsa_state_t;

    vsa_state_t state_reg, state_next;
    vsa_pkg::vsa_cmd_t c;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        c = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    c.load = 1'b1;
                    c.scan_clr = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.func)
                    vsa_pkg::FuncAdd:
                        state_next = S_SCAN;
                    vsa_pkg::FuncRead:
                    begin
                        if (stat.read_ok)
                        begin
                            c.idx_rd = 1'b1;
                            state_next = S_RDWT;
                        end
                        else
                        begin
                            c.out_zero = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                    vsa_pkg::FuncClear:
                    begin
                        c.used_clr = 1'b1;
                        c.out_zero = 1'b1;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        c.out_zero = 1'b1;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    if (stat.full)
                        c.out_full = 1'b1;
                    else
                    begin
                        c.wr_new = 1'b1;
                        c.out_new = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    c.scan_rd = 1'b1;
                    c.scan_inc = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.match)
                begin
                    c.out_hit = 1'b1;
                    c.wr_upd = !stat.sat;
                    state_next = S_DONE;
                end
                else if (stat.scan_done)
                begin
                    if (stat.full)
                        c.out_full = 1'b1;
                    else
                    begin
                        c.wr_new = 1'b1;
                        c.out_new = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    c.scan_rd = 1'b1;
                    c.scan_inc = 1'b1;
                end
            end
            S_RDWT:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                c.out_read = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign cmd  = c;
    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

// ===== bench/tb_voxel_snap_accumulate.sv =====
// Testbench for voxel_snap_accumulate: directed table, then random beats
module tb_voxel_snap_accumulate;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          Depth    = vsa_pkg::TableDepthDefault;
    localparam logic [1:0]  FuncNone = 2'd3;
    localparam int          NumRand  = 530;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic signed [11:0] inten;
        logic [7:0]         r;
        logic [7:0]         g;
        logic [7:0]         b;
        logic [9:0]         ridx;
    } point_beat_t;

    typedef struct packed {
        logic [9:0]         idx;
        logic               is_new;
        logic               dropped;
        logic               valid;
        logic signed [31:0] kx;
        logic signed [31:0] ky;
        logic signed [31:0] kz;
        logic signed [31:0] s_int;
        logic [27:0]        s_r;
        logic [27:0]        s_g;
        logic [27:0]        s_b;
        logic [19:0]        cnt;
    } voxel_res_t;

    typedef enum logic [1:0] { RowBeat, RowTyped, RowCfg } row_kind_e;

    typedef struct {
        row_kind_e   kind;
        point_beat_t beat;
        voxel_res_t  res;
        logic        cfg_idx;
        logic [5:0]  cfg_val;
    } stim_row_t;

    logic clk, rst_n;
    logic start, busy, done;
    logic cfg_valid, cfg_ready, cfg_index;
    logic [5:0] cfg_data;
    logic [1:0] func;
    logic signed [31:0] x_coord, y_coord, z_coord;
    logic signed [11:0] point_intensity;
    logic [7:0] point_red, point_green, point_blue;
    logic [9:0] read_index;
    logic [9:0] entry_index;
    logic is_new, dropped, entry_valid;
    logic signed [31:0] key_x, key_y, key_z, sum_intensity;
    logic [27:0] sum_red, sum_green, sum_blue;
    logic [19:0] point_count;

    voxel_snap_accumulate dut (.*);

    // shadow of the voxel table and registers
    logic [31:0] vt_kx [Depth];
    logic [31:0] vt_ky [Depth];
    logic [31:0] vt_kz [Depth];
    logic [31:0] vt_int [Depth];
    logic [27:0] vt_r [Depth];
    logic [27:0] vt_g [Depth];
    logic [27:0] vt_b [Depth];
    logic [19:0] vt_cnt [Depth];
    int unsigned vt_used;
    logic        sh_en;
    logic signed [5:0] sh_exp;

    voxel_res_t expected_voxels[$];
    int         fail_count;
    int         idle_pct;
    stim_row_t  rows[$];
    logic [31:0] pool_x [8];
    logic [31:0] pool_y [8];
    logic [31:0] pool_z [8];

    initial begin
        clk = 1'b0;
    end

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // round one raw coordinate to the voxel grid, ties toward zero
    function automatic logic [31:0] grid_snap(input logic [31:0] raw);
        int     sh;
        longint v, lim, mag, rem, q, res;
        sh = int'(sh_exp) + vsa_pkg::FracBitsDefault;
        if (!sh_en || sh <= 0)
            return raw;
        if (sh >= 32)
            return '0;
        v   = longint'(signed'(raw));
        lim = longint'(1) << sh;
        mag = v < 0 ? -v : v;
        rem = mag & (lim - 1);
        q   = mag - rem;
        if (rem > lim / 2)
            q += lim;
        res = v < 0 ? -q : q;
        if (res > 64'sd2147483647)
            res = 64'sd2147483648 - lim;
        return res[31:0];
    endfunction

    function automatic voxel_res_t show_voxel(input int unsigned i);
        voxel_res_t o;
        o       = '0;
        o.idx   = i[9:0];
        o.valid = 1'b1;
        o.kx    = vt_kx[i];
        o.ky    = vt_ky[i];
        o.kz    = vt_kz[i];
        o.s_int = vt_int[i];
        o.s_r   = vt_r[i];
        o.s_g   = vt_g[i];
        o.s_b   = vt_b[i];
        o.cnt   = vt_cnt[i];
        return o;
    endfunction

    // next result of the block for one accepted beat; updates the shadow table
    function automatic voxel_res_t accumulate_voxel(input point_beat_t p);
        voxel_res_t  o;
        logic [31:0] kx, ky, kz;
        int unsigned i;
        bit          hit;
        bit          sat;
        o   = '0;
        hit = 1'b0;
        if (p.func == vsa_pkg::FuncAdd) begin
            kx = grid_snap(p.x);
            ky = grid_snap(p.y);
            kz = grid_snap(p.z);
            for (i = 0; i < vt_used; i++) begin
                if (vt_kx[i] == kx && vt_ky[i] == ky && vt_kz[i] == kz) begin
                    hit = 1'b1;
                    break;
                end
            end
            if (hit) begin
                // a hit on a saturated count is dropped and leaves the entry as it is
                sat = (vt_cnt[i] == 20'(vsa_pkg::CountMax));
                if (!sat) begin
                    vt_int[i] += 32'(p.inten);
                    vt_r[i]   += 28'(p.r);
                    vt_g[i]   += 28'(p.g);
                    vt_b[i]   += 28'(p.b);
                    vt_cnt[i] += 1'b1;
                end
                o = show_voxel(i);
                o.dropped = sat;
            end else if (vt_used >= Depth) begin
                o.dropped = 1'b1;
            end else begin
                i = vt_used;
                vt_kx[i]  = kx;
                vt_ky[i]  = ky;
                vt_kz[i]  = kz;
                vt_int[i] = 32'(p.inten);
                vt_r[i]   = 28'(p.r);
                vt_g[i]   = 28'(p.g);
                vt_b[i]   = 28'(p.b);
                vt_cnt[i] = 20'd1;
                vt_used++;
                o = show_voxel(i);
                o.is_new = 1'b1;
            end
        end else if (p.func == vsa_pkg::FuncRead) begin
            o.idx = p.ridx;
            if (p.ridx < vt_used)
                o = show_voxel(p.ridx);
        end else if (p.func == vsa_pkg::FuncClear) begin
            vt_used = 0;
        end
        return o;
    endfunction

    // drive one command beat and queue its expectation once taken
    task automatic send_beat(input point_beat_t p, input bit typed, input voxel_res_t want);
        voxel_res_t o;
        @(negedge clk);
        func            = p.func;
        x_coord         = p.x;
        y_coord         = p.y;
        z_coord         = p.z;
        point_intensity = p.inten;
        point_red       = p.r;
        point_green     = p.g;
        point_blue      = p.b;
        read_index      = p.ridx;
        start           = 1'b1;
        do
            @(posedge clk);
        while (busy);
        o = accumulate_voxel(p);
        expected_voxels.push_back(typed ? want : o);
    endtask

    task automatic sender_gap();
        if ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(4)) @(negedge clk);
        end
    endtask

    // wait for every result, then write one register
    task automatic write_reg(input logic idx, input logic [5:0] val);
        @(negedge clk);
        start = 1'b0;
        while (expected_voxels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == vsa_pkg::CfgSnapEnable)
            sh_en = val[0];
        else
            sh_exp = signed'(val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic point_beat_t add_beat(input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] z, input logic [11:0] i,
                                             input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        point_beat_t p;
        p = '{func: vsa_pkg::FuncAdd, x: x, y: y, z: z, inten: i, r: r, g: g, b: b,
              ridx: '0};
        return p;
    endfunction

    function automatic stim_row_t beat_row(input point_beat_t p);
        stim_row_t s;
        s.kind = RowBeat;
        s.beat = p;
        s.res  = '0;
        s.cfg_idx = 1'b0;
        s.cfg_val = '0;
        return s;
    endfunction

    // command with a typed result: all zero apart from the index
    function automatic stim_row_t zero_row(input logic [1:0] f, input logic [9:0] idx);
        stim_row_t s;
        s = beat_row('0);
        s.kind      = RowTyped;
        s.beat.func = f;
        s.beat.ridx = idx;
        s.res.idx   = idx;
        return s;
    endfunction

    function automatic stim_row_t cfg_row(input logic idx, input logic [5:0] val);
        stim_row_t s;
        s = beat_row('0);
        s.kind    = RowCfg;
        s.cfg_idx = idx;
        s.cfg_val = val;
        return s;
    endfunction

    function automatic point_beat_t random_beat();
        point_beat_t p;
        int          sel, k;
        p     = '0;
        sel   = $urandom_range(99);
        p.func = sel < 72 ? vsa_pkg::FuncAdd : sel < 88 ? vsa_pkg::FuncRead :
                 sel < 96 ? vsa_pkg::FuncClear : FuncNone;
        k     = $urandom_range(7);
        if ($urandom_range(99) < 65) begin
            p.x = pool_x[k] ^ ($urandom & 32'h3FF);
            p.y = pool_y[k] ^ ($urandom & 32'h3FF);
            p.z = pool_z[k] ^ ($urandom & 32'h3FF);
        end else begin
            p.x = $urandom;
            p.y = $urandom;
            p.z = $urandom;
        end
        p.inten = $urandom;
        p.r     = $urandom;
        p.g     = $urandom;
        p.b     = $urandom;
        p.ridx  = $urandom_range(99) < 75 ? 10'($urandom_range(vt_used + 2)) : 10'($urandom);
        return p;
    endfunction

    // check each shown result against the oldest expectation
    always @(posedge clk) begin
        voxel_res_t w;
        if (rst_n && done) begin
            if (expected_voxels.size() == 0) begin
                report_mismatch("result with nothing expected", entry_index, 0);
            end else begin
                w = expected_voxels.pop_front();
                if (entry_index !== w.idx)     report_mismatch("entry_index", entry_index, w.idx);
                if (is_new !== w.is_new)       report_mismatch("is_new", is_new, w.is_new);
                if (dropped !== w.dropped)     report_mismatch("dropped", dropped, w.dropped);
                if (entry_valid !== w.valid)   report_mismatch("entry_valid", entry_valid, w.valid);
                if (key_x !== w.kx)            report_mismatch("key_x", key_x, w.kx);
                if (key_y !== w.ky)            report_mismatch("key_y", key_y, w.ky);
                if (key_z !== w.kz)            report_mismatch("key_z", key_z, w.kz);
                if (sum_intensity !== w.s_int)
                    report_mismatch("sum_intensity", sum_intensity, w.s_int);
                if (sum_red !== w.s_r)         report_mismatch("sum_red", sum_red, w.s_r);
                if (sum_green !== w.s_g)       report_mismatch("sum_green", sum_green, w.s_g);
                if (sum_blue !== w.s_b)        report_mismatch("sum_blue", sum_blue, w.s_b);
                if (point_count !== w.cnt)     report_mismatch("point_count", point_count, w.cnt);
            end
        end
    end

    // run limit
    initial begin
        #10ms;
        $display("voxel_snap_accumulate test failed");
        $finish;
    end

    initial begin
        point_beat_t p;
        int          waited;
        start = 1'b0; cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        func = vsa_pkg::FuncAdd; x_coord = '0; y_coord = '0; z_coord = '0;
        point_intensity = '0;
        point_red = '0; point_green = '0; point_blue = '0; read_index = '0;
        vt_used = 0; sh_en = 1'b0; sh_exp = '0; fail_count = 0; idle_pct = 18;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: reset state, extremes, rounding corners
        rows.push_back(zero_row(vsa_pkg::FuncRead, 10'd0));
        rows.push_back(zero_row(vsa_pkg::FuncRead, 10'd1023));
        rows.push_back(zero_row(FuncNone, 10'd0));
        rows.push_back(zero_row(vsa_pkg::FuncClear, 10'd0));
        rows.push_back(beat_row(add_beat(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                         12'h7FF, 8'hFF, 8'hFF, 8'hFF)));
        rows.push_back(beat_row(add_beat(32'h80000000, 32'h80000000, 32'h80000000,
                                         12'h800, 8'h00, 8'h00, 8'h00)));
        rows.push_back(beat_row(add_beat(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                         12'h800, 8'hFF, 8'h00, 8'h80)));
        p = '0; p.func = vsa_pkg::FuncRead; p.ridx = 10'd1;
        rows.push_back(beat_row(p));
        rows.push_back(zero_row(vsa_pkg::FuncRead, 10'd2));
        rows.push_back(cfg_row(vsa_pkg::CfgSnapEnable, 6'd1));
        rows.push_back(cfg_row(vsa_pkg::CfgSnapExp, 6'd0));
        // past the top, a tie toward zero on both signs
        rows.push_back(beat_row(add_beat(32'h7FFFFFFF, 32'h00000180, 32'hFFFFFE80,
                                         12'h123, 8'h01, 8'h02, 8'h03)));
        rows.push_back(beat_row(add_beat(32'h0000017F, 32'h80000000, 32'hFFFFFE81,
                                         12'hFFF, 8'h10, 8'h20, 8'h30)));
        rows.push_back(cfg_row(vsa_pkg::CfgSnapExp, 6'h38));
        rows.push_back(beat_row(add_beat(32'h12345678, 32'h9ABCDEF0, 32'h00000001,
                                         12'h001, 8'h55, 8'hAA, 8'h5A)));
        rows.push_back(cfg_row(vsa_pkg::CfgSnapExp, 6'd22));
        rows.push_back(beat_row(add_beat(32'h60000000, 32'hA0000000, 32'h5FFFFFFF,
                                         12'h400, 8'h7F, 8'h80, 8'hFE)));
        rows.push_back(cfg_row(vsa_pkg::CfgSnapExp, 6'd31));
        rows.push_back(beat_row(add_beat(32'hDEADBEEF, 32'h7FFFFFFF, 32'h80000000,
                                         12'h7FF, 8'h01, 8'h01, 8'h01)));
        rows.push_back(cfg_row(vsa_pkg::CfgSnapExp, 6'h20));
        rows.push_back(beat_row(add_beat(32'h00000081, 32'hFFFFFF7F, 32'h00000000,
                                         12'h000, 8'h00, 8'hFF, 8'h00)));
        rows.push_back(cfg_row(vsa_pkg::CfgSnapEnable, 6'd0));
        rows.push_back(zero_row(vsa_pkg::FuncClear, 10'd0));
        rows.push_back(zero_row(vsa_pkg::FuncRead, 10'd0));
        foreach (rows[i]) begin
            if (rows[i].kind == RowCfg)
                write_reg(rows[i].cfg_idx, rows[i].cfg_val);
            else
                send_beat(rows[i].beat, rows[i].kind == RowTyped, rows[i].res);
        end

        // random part in three idling phases
        for (int n = 0; n < NumRand; n++) begin
            if (n == NumRand / 3)
                idle_pct = 52;
            else if (n == 2 * NumRand / 3)
                idle_pct = 0;
            if (n % 50 == 0) begin
                write_reg(vsa_pkg::CfgSnapEnable, 6'($urandom_range(99) < 70));
                case ($urandom_range(5))
                    0: write_reg(vsa_pkg::CfgSnapExp, 6'h38);
                    1: write_reg(vsa_pkg::CfgSnapExp, 6'd22);
                    2: write_reg(vsa_pkg::CfgSnapExp, 6'($urandom));
                    default: write_reg(vsa_pkg::CfgSnapExp, 6'($urandom_range(10)));
                endcase
                foreach (pool_x[k]) begin
                    pool_x[k] = $urandom;
                    pool_y[k] = $urandom;
                    pool_z[k] = $urandom;
                end
            end
            sender_gap();
            send_beat(random_beat(), 1'b0, '0);
        end
        @(negedge clk);
        start = 1'b0;

        waited = 0;
        while (expected_voxels.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (Depth + 10) @(posedge clk);
        if (fail_count == 0 && expected_voxels.size() == 0)
            $display("voxel_snap_accumulate test passed");
        else
            $display("voxel_snap_accumulate test failed");
        $finish;
    end

endmodule

// ===== voxel_snap_accumulate.f =====
hdl/vsa_pkg.sv
hdl/vsa_datapath.sv
hdl/vsa_ctrl.sv
hdl/voxel_snap_accumulate.sv
bench/tb_voxel_snap_accumulate.sv
